FILE: rtl/ptr_pkg.sv
package ptr_pkg;

  localparam int unsigned TILE_COUNT_DEF      = 256;
  localparam int unsigned TILE_PIXELS_DEF     = 64;
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned TILE_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CIDX_W = 8;
  localparam int unsigned RGB_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW    = 2'd0,
    OP_TILE_WR = 2'd1,
    OP_PAL_WR  = 2'd2
  } op_e;

  // requests from the controller to the tile and palette stores
  typedef struct packed {
    logic              tile_we;
    logic              pal_we;
    logic              fill_start;
    logic [TILE_W-1:0] tile;
    logic [SLOT_W-1:0] slot;
    logic [CIDX_W-1:0] cidx;
    logic [RGB_W-1:0]  rgb;
  } store_cmd_t;

  // converted pixels on their way into the pixel cache
  typedef struct packed {
    logic              we;
    logic              done;
    logic [SLOT_W-1:0] idx;
    logic [RGB_W-1:0]  rgb;
  } cache_wr_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } emit_cmd_t;

endpackage

FILE: rtl/ptr_if.sv
interface ptr_in_if;
  import ptr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TILE_W-1:0] tile_number;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [SLOT_W-1:0] pixel_slot;
  logic [CIDX_W-1:0] color_index;
  logic [RGB_W-1:0]  rgb_value;

  modport source (
    output valid, op, tile_number, pos_x, pos_y, pixel_slot, color_index, rgb_value,
    input  ready
  );

  modport sink (
    input  valid, op, tile_number, pos_x, pos_y, pixel_slot, color_index, rgb_value,
    output ready
  );
endinterface

interface ptr_out_if;
  import ptr_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  win_x;
  logic [POS_W-1:0]  win_y;
  logic [SLOT_W-1:0] pixel_number;
  logic [RGB_W-1:0]  pixel_rgb;
  logic              last;

  modport source (
    output valid, win_x, win_y, pixel_number, pixel_rgb, last,
    input  ready
  );

  modport sink (
    input  valid, win_x, win_y, pixel_number, pixel_rgb, last,
    output ready
  );
endinterface

FILE: rtl/ptr_store.sv
module ptr_store #(
  parameter int unsigned TILE_COUNT      = ptr_pkg::TILE_COUNT_DEF,
  parameter int unsigned TILE_PIXELS     = ptr_pkg::TILE_PIXELS_DEF,
  parameter int unsigned PALETTE_ENTRIES = ptr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptr_pkg::store_cmd_t cmd_i,
  output ptr_pkg::cache_wr_t  cwr_o,
  output logic                clr_busy_o
);
  import ptr_pkg::*;

  localparam int unsigned TILE_DEPTH = TILE_COUNT * TILE_PIXELS;
  localparam int unsigned TA_W  = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
  localparam int unsigned PA_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned IDX_W = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
  localparam int unsigned CLR_N = (TILE_DEPTH > PALETTE_ENTRIES) ? TILE_DEPTH : PALETTE_ENTRIES;
  localparam int unsigned CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TILE_PIXELS - 1);

  logic [CIDX_W-1:0] tile_mem [TILE_DEPTH];
  logic [RGB_W-1:0]  pal_mem  [PALETTE_ENTRIES];

  logic             clr_busy_q;
  logic [CLR_W-1:0] clr_q, clr_d;

  logic              fill_act_q;
  logic [IDX_W-1:0]  k_q;
  logic [TA_W-1:0]   base_q;
  logic              s1_q, s2_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q;
  logic              inr2_q;

  logic              t_we, t_re, p_we, p_re;
  logic [TA_W-1:0]   t_wa, t_ra;
  logic [CIDX_W-1:0] t_wd, t_rd_q;
  logic [PA_W-1:0]   p_wa, p_ra;
  logic [RGB_W-1:0]  p_wd, p_rd_q;

  logic tile_ok, slot_ok, pal_ok, inr;

  assign tile_ok = {1'b0, cmd_i.tile} < (TILE_W+1)'(TILE_COUNT);
  assign slot_ok = {1'b0, cmd_i.slot} < (SLOT_W+1)'(TILE_PIXELS);
  assign pal_ok  = {1'b0, cmd_i.cidx} < (CIDX_W+1)'(PALETTE_ENTRIES);
  assign clr_d   = clr_q + CLR_W'(1);

  // clearing sweep owns the write ports after reset
  always_comb begin
    if (clr_busy_q) begin
      t_we = {1'b0, clr_q} < (CLR_W+1)'(TILE_DEPTH);
      t_wa = TA_W'(clr_q);
      t_wd = '0;
      p_we = {1'b0, clr_q} < (CLR_W+1)'(PALETTE_ENTRIES);
      p_wa = PA_W'(clr_q);
      p_wd = '0;
    end else begin
      t_we = cmd_i.tile_we && tile_ok && slot_ok;
      t_wa = TA_W'(32'(cmd_i.tile) * TILE_PIXELS + 32'(cmd_i.slot));
      t_wd = cmd_i.cidx;
      p_we = cmd_i.pal_we && pal_ok;
      p_wa = PA_W'(cmd_i.cidx);
      p_wd = cmd_i.rgb;
    end
  end

  assign t_re = fill_act_q;
  assign t_ra = base_q + TA_W'(k_q);
  assign p_re = s1_q;
  assign p_ra = PA_W'(t_rd_q);
  assign inr  = {1'b0, t_rd_q} < (CIDX_W+1)'(PALETTE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (t_we) tile_mem[t_wa] <= t_wd;
    if (t_re) t_rd_q <= tile_mem[t_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pal_mem[p_wa] <= p_wd;
    if (p_re) p_rd_q <= pal_mem[p_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
      fill_act_q <= 1'b0;
      k_q        <= '0;
      s1_q       <= 1'b0;
      s2_q       <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_d;
        if (clr_q == CLR_W'(CLR_N - 1)) clr_busy_q <= 1'b0;
      end
      if (cmd_i.fill_start) begin
        fill_act_q <= 1'b1;
        k_q        <= '0;
      end else if (fill_act_q) begin
        k_q <= k_q + IDX_W'(1);
        if (k_q == IDX_LAST) fill_act_q <= 1'b0;
      end
      s1_q <= fill_act_q;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_start) base_q <= TA_W'(32'(cmd_i.tile) * TILE_PIXELS);
    idx1_q <= k_q;
    idx2_q <= idx1_q;
    inr2_q <= inr;
  end

  // indexes past the palette convert to black
  assign cwr_o.we   = s2_q;
  assign cwr_o.done = s2_q && (idx2_q == IDX_LAST);
  assign cwr_o.idx  = SLOT_W'(idx2_q);
  assign cwr_o.rgb  = inr2_q ? p_rd_q : '0;
  assign clr_busy_o = clr_busy_q;

  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_start |-> !clr_busy_q && !fill_act_q && !s1_q && !s2_q)
    else $error("fill started while store busy");

  a_wr_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tile_we || cmd_i.pal_we) |-> !fill_act_q && !s1_q && !s2_q)
    else $error("store write during conversion");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q && (idx2_q != IDX_LAST)) |=> s2_q && (idx2_q == $past(idx2_q) + IDX_W'(1)))
    else $error("conversion skipped a pixel");

endmodule

FILE: rtl/ptr_cache.sv
module ptr_cache #(
  parameter int unsigned TILE_PIXELS = ptr_pkg::TILE_PIXELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptr_pkg::cache_wr_t cwr_i,
  input  ptr_pkg::emit_cmd_t emit_i,
  output logic               emit_done_o,
  ptr_out_if.source          out_o
);
  import ptr_pkg::*;

  localparam int unsigned IDX_W = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TILE_PIXELS - 1);

  logic [RGB_W-1:0] cache_mem [TILE_PIXELS];

  logic             rd_act_q;
  logic [IDX_W-1:0] rk_q;
  logic             d_vld_q;
  logic [IDX_W-1:0] d_idx_q;
  logic [RGB_W-1:0] c_rd_q;
  logic             ov_q;
  logic [IDX_W-1:0] o_idx_q;
  logic [RGB_W-1:0] o_rgb_q;
  logic             o_last_q;
  logic [POS_W-1:0] win_x_q, win_y_q;

  logic move, re;

  // read data stays in the memory output register until it moves on
  assign move = d_vld_q && (!ov_q || out_o.ready);
  assign re   = rd_act_q && (!d_vld_q || move);

  always_ff @(posedge clk_i) begin
    if (cwr_i.we) cache_mem[IDX_W'(cwr_i.idx)] <= cwr_i.rgb;
    if (re) c_rd_q <= cache_mem[rk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q <= 1'b0;
      rk_q     <= '0;
      d_vld_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (emit_i.start) begin
        rd_act_q <= 1'b1;
        rk_q     <= '0;
      end else if (re) begin
        rk_q <= rk_q + IDX_W'(1);
        if (rk_q == IDX_LAST) rd_act_q <= 1'b0;
      end
      if (re) begin
        d_vld_q <= 1'b1;
      end else if (move) begin
        d_vld_q <= 1'b0;
      end
      if (move) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) d_idx_q <= rk_q;
    if (move) begin
      o_idx_q  <= d_idx_q;
      o_rgb_q  <= c_rd_q;
      o_last_q <= (d_idx_q == IDX_LAST);
    end
    if (emit_i.start) begin
      win_x_q <= emit_i.pos_x;
      win_y_q <= emit_i.pos_y;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.win_x        = win_x_q;
  assign out_o.win_y        = win_y_q;
  assign out_o.pixel_number = SLOT_W'(o_idx_q);
  assign out_o.pixel_rgb    = o_rgb_q;
  assign out_o.last         = o_last_q;
  assign emit_done_o        = ov_q && out_o.ready && o_last_q;

  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.start |-> !rd_act_q && !d_vld_q && !ov_q)
    else $error("emit started with pixels in flight");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_vld_q && !move) |=> d_vld_q && $stable(c_rd_q) && $stable(d_idx_q))
    else $error("pending read data lost");

  a_no_wr_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cwr_i.we |-> !rd_act_q && !d_vld_q && !ov_q)
    else $error("cache written while emitting");

endmodule

FILE: rtl/palette_tile_renderer_core.sv
// Indexed-color 8x8 tile renderer. Input beats either write one tile pixel index, write
// one palette color, or draw a tile at a window origin; writes give no output, and a beat
// with the unused opcode is taken and dropped. A draw of the cached tile streams its pixels
// from the pixel cache memory at one beat per cycle while the output is ready; a miss
// first runs the tile memory and palette memory reads as a two-deep pipeline, one pixel a
// cycle, and streams once the last converted pixel lands. One item is in work at a time
// and ready stays low until the last beat of a draw is taken. Writes to tiles or palette
// leave the cache alone, so a redraw of the cached tile keeps its old colors. After reset
// a clearing pass zeroes both stores, sweeping max(TILE_COUNT * TILE_PIXELS,
// PALETTE_ENTRIES) addresses (16384 by default), before the first beat is accepted.
module palette_tile_renderer_core #(
  parameter int unsigned TILE_COUNT      = ptr_pkg::TILE_COUNT_DEF,
  parameter int unsigned TILE_PIXELS     = ptr_pkg::TILE_PIXELS_DEF,
  parameter int unsigned PALETTE_ENTRIES = ptr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptr_in_if.sink    in_i,
  ptr_out_if.source out_o
);
  import ptr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [TILE_W-1:0] cached_tile_q;
  logic              cache_vld_q;

  store_cmd_t scmd;
  cache_wr_t  cwr;
  emit_cmd_t  ecmd;
  logic       clr_busy, emit_done;
  logic       accept, tile_ok, hit, draw, is_draw, is_tile_wr, is_pal_wr;
  logic [POS_W-1:0] pos_x_q, pos_y_q;

  assign in_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign accept     = in_i.valid && in_i.ready;
  assign tile_ok    = {1'b0, in_i.tile_number} < (TILE_W+1)'(TILE_COUNT);
  assign hit        = cache_vld_q && (cached_tile_q == in_i.tile_number);

  always_comb begin
    is_draw    = 1'b0;
    is_tile_wr = 1'b0;
    is_pal_wr  = 1'b0;
    unique case (in_i.op)
      OP_DRAW:    is_draw    = 1'b1;
      OP_TILE_WR: is_tile_wr = 1'b1;
      OP_PAL_WR:  is_pal_wr  = 1'b1;
      default:    ;
    endcase
  end

  assign draw = accept && is_draw && tile_ok;

  assign scmd.tile_we    = accept && is_tile_wr;
  assign scmd.pal_we     = accept && is_pal_wr;
  assign scmd.fill_start = draw && !hit;
  assign scmd.tile       = in_i.tile_number;
  assign scmd.slot       = in_i.pixel_slot;
  assign scmd.cidx       = in_i.color_index;
  assign scmd.rgb        = in_i.rgb_value;

  // a hit streams at once, a miss streams when the last converted pixel lands
  assign ecmd.start = (draw && hit) || cwr.done;
  assign ecmd.pos_x = draw ? in_i.pos_x : pos_x_q;
  assign ecmd.pos_y = draw ? in_i.pos_y : pos_y_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (draw) state_d = hit ? S_EMIT : S_FILL;
      S_FILL: if (cwr.done) state_d = S_EMIT;
      S_EMIT: if (emit_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cached_tile_q <= '0;
      cache_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (scmd.fill_start) begin
        cached_tile_q <= in_i.tile_number;
        cache_vld_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      pos_x_q <= in_i.pos_x;
      pos_y_q <= in_i.pos_y;
    end
  end

  ptr_store #(
    .TILE_COUNT      (TILE_COUNT),
    .TILE_PIXELS     (TILE_PIXELS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (scmd),
    .cwr_o      (cwr),
    .clr_busy_o (clr_busy)
  );

  ptr_cache #(
    .TILE_PIXELS (TILE_PIXELS)
  ) u_cache (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cwr_i       (cwr),
    .emit_i      (ecmd),
    .emit_done_o (emit_done),
    .out_o       (out_o)
  );

  a_fill_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cwr.done |-> state_q == S_FILL)
    else $error("conversion finished outside fill");

  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> state_q == S_EMIT)
    else $error("output beat outside emit");

  a_emit_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_done |=> state_q == S_IDLE && !out_o.valid)
    else $error("draw did not retire after last beat");

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptr_pkg::*;

  localparam int TILES      = TILE_COUNT_DEF;
  localparam int TPIX       = TILE_PIXELS_DEF;
  localparam int PAL_SIZE   = PALETTE_ENTRIES_DEF;
  localparam int RAND_ITEMS = 352;
  localparam int DRAIN_CYC  = 160;
  localparam int HOLD_CYC   = 400;
  // clearing pass plus every item as a draw with the longest gaps and stalls, taken 4x
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TILE_W-1:0] tile;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [SLOT_W-1:0] slot;
    logic [CIDX_W-1:0] cidx;
    logic [RGB_W-1:0]  rgb;
  } beat_req_t;

  typedef struct {
    logic [POS_W-1:0]  win_x;
    logic [POS_W-1:0]  win_y;
    logic [SLOT_W-1:0] pixel_number;
    logic [RGB_W-1:0]  pixel_rgb;
    logic              last;
  } pixel_t;

  typedef struct {
    beat_req_t        req;
    bit               pinned;
    logic [RGB_W-1:0] pin_rgb;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ptr_in_if  in_bus ();
  ptr_out_if out_bus ();

  palette_tile_renderer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predicted block state
  logic [CIDX_W-1:0] tile_mem [TILES*TPIX];
  logic [RGB_W-1:0]  pal_mem [PAL_SIZE];
  logic [RGB_W-1:0]  cache_rgb [TPIX];
  logic [TILE_W-1:0] cache_tile;
  logic              cache_live;

  pixel_t    pixel_q [$];
  stim_row_t stim_rows [$];

  int err_cnt;
  int cycle_cnt;
  int sink_hold;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_wait();
    if (quiet) return 0;
    return $urandom_range(17, 0);
  endfunction

  function automatic void render_expected(input beat_req_t r);
    pixel_t p;
    int     base;
    case (r.op)
      OP_TILE_WR: tile_mem[int'(r.tile) * TPIX + int'(r.slot)] = r.cidx;
      OP_PAL_WR:  pal_mem[r.cidx] = r.rgb;
      OP_DRAW: begin
        if (!cache_live || cache_tile != r.tile) begin
          base = int'(r.tile) * TPIX;
          for (int k = 0; k < TPIX; k++) cache_rgb[k] = pal_mem[tile_mem[base + k]];
          cache_tile = r.tile;
          cache_live = 1'b1;
        end
        for (int k = 0; k < TPIX; k++) begin
          p.win_x        = r.px;
          p.win_y        = r.py;
          p.pixel_number = SLOT_W'(k);
          p.pixel_rgb    = cache_rgb[k];
          p.last         = (k == TPIX - 1);
          pixel_q.push_back(p);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [TILE_W-1:0] tile,
                                  input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                  input logic [SLOT_W-1:0] slot,
                                  input logic [CIDX_W-1:0] cidx,
                                  input logic [RGB_W-1:0] rgb, input bit pinned,
                                  input logic [RGB_W-1:0] pin_rgb);
    stim_row_t row;
    row.req.op   = op;
    row.req.tile = tile;
    row.req.px   = px;
    row.req.py   = py;
    row.req.slot = slot;
    row.req.cidx = cidx;
    row.req.rgb  = rgb;
    row.pinned   = pinned;
    row.pin_rgb  = pin_rgb;
    stim_rows.push_back(row);
  endfunction

  task automatic send_beat(input beat_req_t r, input bit pinned,
                           input logic [RGB_W-1:0] pin_rgb);
    int gap;
    int n0;
    gap = pick_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.op          <= r.op;
    in_bus.tile_number <= r.tile;
    in_bus.pos_x       <= r.px;
    in_bus.pos_y       <= r.py;
    in_bus.pixel_slot  <= r.slot;
    in_bus.color_index <= r.cidx;
    in_bus.rgb_value   <= r.rgb;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    n0 = pixel_q.size();
    render_expected(r);
    if (pinned) for (int k = n0; k < pixel_q.size(); k++) pixel_q[k].pixel_rgb = pin_rgb;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  // output side: random stall per beat, or one long hold when asked for
  initial begin : sink_side
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = pick_wait();
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pixel_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected pixel beat x=%0d y=%0d n=%0d rgb=%h last=%b", $time,
                   out_bus.win_x, out_bus.win_y, out_bus.pixel_number, out_bus.pixel_rgb,
                   out_bus.last);
      end else begin
        exp_px = pixel_q.pop_front();
        if (out_bus.win_x !== exp_px.win_x || out_bus.win_y !== exp_px.win_y ||
            out_bus.pixel_number !== exp_px.pixel_number ||
            out_bus.pixel_rgb !== exp_px.pixel_rgb || out_bus.last !== exp_px.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: pixel mismatch exp x=%0d y=%0d n=%0d rgb=%h last=%b, got x=%0d y=%0d n=%0d rgb=%h last=%b",
                     $time, exp_px.win_x, exp_px.win_y, exp_px.pixel_number,
                     exp_px.pixel_rgb, exp_px.last, out_bus.win_x, out_bus.win_y,
                     out_bus.pixel_number, out_bus.pixel_rgb, out_bus.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    beat_req_t         r;
    logic [TILE_W-1:0] focus_tile [4];
    logic [TILE_W-1:0] last_drawn;
    int                counted;
    int                sel;
    bit                hold_done;
    bit                pause_done;

    err_cnt    = 0;
    cycle_cnt  = 0;
    sink_hold  = 0;
    quiet      = 1'b0;
    cache_tile = '0;
    cache_live = 1'b0;
    for (int i = 0; i < TILES * TPIX; i++) tile_mem[i] = '0;
    for (int i = 0; i < PAL_SIZE; i++) pal_mem[i] = '0;
    for (int i = 0; i < TPIX; i++) cache_rgb[i] = '0;

    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.op          <= OP_DRAW;
    in_bus.tile_number <= '0;
    in_bus.pos_x       <= '0;
    in_bus.pos_y       <= '0;
    in_bus.pixel_slot  <= '0;
    in_bus.color_index <= '0;
    in_bus.rgb_value   <= '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset every store reads zero
    add_row(OP_DRAW,    8'd0,   10'd0,    10'd0,    6'd0,  8'd0,   16'h0000, 1, 16'h0000);
    add_row(OP_DRAW,    8'd255, 10'd1023, 10'd1023, 6'd0,  8'd0,   16'h0000, 1, 16'h0000);
    add_row(OP_PAL_WR,  8'd0,   10'd0,    10'd0,    6'd0,  8'd0,   16'hFFFF, 0, 16'h0000);
    // same tile again: cache hit keeps the colors it was filled with
    add_row(OP_DRAW,    8'd255, 10'd512,  10'd0,    6'd0,  8'd0,   16'h0000, 1, 16'h0000);
    add_row(OP_DRAW,    8'd0,   10'd0,    10'd1023, 6'd0,  8'd0,   16'h0000, 1, 16'hFFFF);
    add_row(OP_TILE_WR, 8'd255, 10'd0,    10'd0,    6'd63, 8'd255, 16'h0000, 0, 16'h0000);
    add_row(OP_TILE_WR, 8'd255, 10'd0,    10'd0,    6'd0,  8'd1,   16'h0000, 0, 16'h0000);
    add_row(OP_TILE_WR, 8'd0,   10'd0,    10'd0,    6'd63, 8'd128, 16'h0000, 0, 16'h0000);
    add_row(OP_PAL_WR,  8'd0,   10'd0,    10'd0,    6'd0,  8'd1,   16'hA5A5, 0, 16'h0000);
    add_row(OP_PAL_WR,  8'd0,   10'd0,    10'd0,    6'd0,  8'd255, 16'h5A5A, 0, 16'h0000);
    add_row(OP_PAL_WR,  8'd0,   10'd0,    10'd0,    6'd0,  8'd128, 16'h8000, 0, 16'h0000);
    add_row(OP_UNUSED,  8'd255, 10'd1023, 10'd1023, 6'd63, 8'd255, 16'hFFFF, 0, 16'h0000);
    add_row(OP_DRAW,    8'd255, 10'd1023, 10'd0,    6'd0,  8'd0,   16'h0000, 0, 16'h0000);
    add_row(OP_DRAW,    8'd0,   10'd341,  10'd682,  6'd0,  8'd0,   16'h0000, 0, 16'h0000);
    add_row(OP_PAL_WR,  8'd0,   10'd0,    10'd0,    6'd0,  8'd0,   16'h0000, 0, 16'h0000);
    add_row(OP_DRAW,    8'd0,   10'd0,    10'd0,    6'd0,  8'd0,   16'h0000, 0, 16'h0000);
    add_row(OP_TILE_WR, 8'd7,   10'd0,    10'd0,    6'd21, 8'd42,  16'h0000, 0, 16'h0000);
    add_row(OP_DRAW,    8'd7,   10'd1,    10'd1,    6'd0,  8'd0,   16'h0000, 0, 16'h0000);
    add_row(OP_DRAW,    8'd7,   10'd1023, 10'd512,  6'd0,  8'd0,   16'h0000, 0, 16'h0000);

    foreach (stim_rows[i]) send_beat(stim_rows[i].req, stim_rows[i].pinned,
                                     stim_rows[i].pin_rgb);

    focus_tile[0] = 8'd0;
    focus_tile[1] = 8'd255;
    focus_tile[2] = TILE_W'($urandom);
    focus_tile[3] = TILE_W'($urandom);
    last_drawn    = 8'd7;
    counted       = 0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;

    while (counted < RAND_ITEMS) begin
      // every third stretch of thirty items runs with no idling on either side
      quiet = ((counted / 30) % 3 == 1);
      r.tile = TILE_W'($urandom);
      r.px   = POS_W'($urandom);
      r.py   = POS_W'($urandom);
      r.slot = SLOT_W'($urandom);
      r.cidx = CIDX_W'($urandom);
      r.rgb  = RGB_W'($urandom);
      sel = $urandom_range(99, 0);
      if (sel < 5) begin
        r.op = OP_UNUSED;
      end else if (sel < 45) begin
        r.op = OP_TILE_WR;
        if ($urandom_range(3, 0) != 0) r.tile = focus_tile[$urandom_range(3, 0)];
      end else if (sel < 68) begin
        r.op = OP_PAL_WR;
      end else begin
        r.op = OP_DRAW;
        sel = $urandom_range(99, 0);
        if (sel < 35) r.tile = last_drawn;
        else if (sel < 80) r.tile = focus_tile[$urandom_range(3, 0)];
        last_drawn = r.tile;
      end
      send_beat(r, 1'b0, '0);
      if (r.op != OP_UNUSED) counted++;

      // output side stops for a long while; the next draws back up behind it
      if (!hold_done && counted > 100 && r.op == OP_DRAW) begin
        sink_hold = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (!pause_done && counted > 220) begin
        drop_valid();
        while (pixel_q.size() != 0) @(posedge clk_i);
        pause_done = 1'b1;
      end
    end

    drop_valid();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
